// ===== hdl/bclp_pkg.sv =====
// Package: widths, mode and report codes, register indexes and reset values for the classifier.
`timescale 1ns / 1ps

package bclp_pkg;

  // Field widths
  localparam int unsigned MS_W    = 16;
  localparam int unsigned HELD_W  = 20;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned LONG_W  = 16;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 20;

  // Saturation limits
  localparam logic [HELD_W-1:0]  HELD_MAX  = {HELD_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Register reset values
  localparam logic [LONG_W-1:0] LONG_PRESS_RST    = 16'd300;
  localparam logic [HELD_W-1:0] FIRST_LOW_RST     = 20'd2930;
  localparam logic [HELD_W-1:0] FIRST_HIGH_RST    = 20'd3080;
  localparam logic [HELD_W-1:0] SECOND_LOW_RST    = 20'd7930;
  localparam logic [HELD_W-1:0] SECOND_HIGH_RST   = 20'd8080;

  // Level of the key input when released
  localparam logic KEY_UP_LEVEL = 1'b0;

  typedef enum logic [1:0] {
    MODE_RELEASED = 2'd0,
    MODE_SINGLE   = 2'd1,
    MODE_LONG     = 2'd2,
    MODE_REPEAT   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    RPT_NONE   = 2'd0,
    RPT_CLICKS = 2'd1,
    RPT_FIRST  = 2'd2,
    RPT_SECOND = 2'd3
  } report_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_LONG_PRESS  = 3'd0,
    CFG_FIRST_LOW   = 3'd1,
    CFG_FIRST_HIGH  = 3'd2,
    CFG_SECOND_LOW  = 3'd3,
    CFG_SECOND_HIGH = 3'd4
  } cfg_idx_e;

  // Result item as held in the output register
  typedef struct packed {
    report_e              report_kind;
    logic [COUNT_W-1:0]   click_total;
    mode_e                mode_now;
  } result_t;

endpackage

// ===== hdl/bclp_evt_if.sv =====
// Interface: key event channel (key level and elapsed milliseconds).
`timescale 1ns / 1ps

interface bclp_evt_if;
  import bclp_pkg::*;

  logic            valid;
  logic            ready;
  logic            key_pressed;
  logic [MS_W-1:0] elapsed_ms;

  modport source (output valid, output key_pressed, output elapsed_ms, input ready);
  modport sink   (input valid, input key_pressed, input elapsed_ms, output ready);
endinterface

// ===== hdl/bclp_res_if.sv =====
// Interface: classification result channel.
`timescale 1ns / 1ps

interface bclp_res_if;
  import bclp_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         report_kind;
  logic [COUNT_W-1:0] click_total;
  logic [1:0]         mode_now;

  modport source (output valid, output report_kind, output click_total, output mode_now,
                  input ready);
  modport sink   (input valid, input report_kind, input click_total, input mode_now,
                  output ready);
endinterface

// ===== hdl/bclp_cfg_if.sv =====
// Interface: configuration register write channel.
`timescale 1ns / 1ps

interface bclp_cfg_if;
  import bclp_pkg::*;

  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/button_click_long_press_classifier.sv =====
// Top level: key click and long-press classifier with registered result output.
// A result appears on the output in the cycle after its event transaction.
// Throughput: one event per cycle while the output register is empty or being drained;
// the state update is a single 20-bit add with saturation and five compares, done in
// the accept cycle into the state registers. A drain and a new load may share a cycle.
// Reset: mode released, held time and click count zero, registers at default values.
`timescale 1ns / 1ps

module button_click_long_press_classifier (
  input  logic clk_i,
  input  logic rst_ni,
  bclp_cfg_if.sink   cfg_i,
  bclp_evt_if.sink   evt_i,
  bclp_res_if.source res_o
);
  import bclp_pkg::*;

  // Configuration registers
  logic [LONG_W-1:0] long_press_q;
  logic [HELD_W-1:0] first_low_q;
  logic [HELD_W-1:0] first_high_q;
  logic [HELD_W-1:0] second_low_q;
  logic [HELD_W-1:0] second_high_q;

  // Classifier state
  mode_e              mode_q, mode_d;
  logic [HELD_W-1:0]  held_q, held_d;
  logic [COUNT_W-1:0] count_q, count_d;

  // Output register
  logic    res_valid_q, res_valid_d;
  result_t res_q, res_d;

  logic              evt_accept;
  logic              released_evt;
  logic [HELD_W:0]   held_sum;
  logic [HELD_W-1:0] held_acc;
  logic              in_first;
  logic              in_second;
  report_e           kind;
  logic [COUNT_W-1:0] total;

  assign cfg_i.ready = 1'b1;

  // Take register writes; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q  <= LONG_PRESS_RST;
      first_low_q   <= FIRST_LOW_RST;
      first_high_q  <= FIRST_HIGH_RST;
      second_low_q  <= SECOND_LOW_RST;
      second_high_q <= SECOND_HIGH_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LONG_PRESS:  long_press_q  <= cfg_i.data[LONG_W-1:0];
        CFG_FIRST_LOW:   first_low_q   <= cfg_i.data[HELD_W-1:0];
        CFG_FIRST_HIGH:  first_high_q  <= cfg_i.data[HELD_W-1:0];
        CFG_SECOND_LOW:  second_low_q  <= cfg_i.data[HELD_W-1:0];
        CFG_SECOND_HIGH: second_high_q <= cfg_i.data[HELD_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept while the output register is empty or being drained
  assign evt_i.ready = !res_valid_q || res_o.ready;
  assign evt_accept  = evt_i.valid && evt_i.ready;
  assign released_evt = (evt_i.key_pressed == KEY_UP_LEVEL);

  // Accumulate held time with saturation
  assign held_sum = {1'b0, held_q} + {{(HELD_W + 1 - MS_W){1'b0}}, evt_i.elapsed_ms};
  assign held_acc = held_sum[HELD_W] ? HELD_MAX : held_sum[HELD_W-1:0];

  // Hold mark windows, both bounds exclusive
  assign in_first  = (held_acc > first_low_q) && (held_acc < first_high_q);
  assign in_second = (held_acc > second_low_q) && (held_acc < second_high_q);

  // Next state
  always_comb begin
    mode_d  = mode_q;
    held_d  = held_q;
    count_d = count_q;
    if (evt_accept) begin
      case (mode_q)
        MODE_RELEASED: begin
          if (released_evt) begin
            held_d  = '0;
            count_d = '0;
          end else begin
            mode_d = (count_q != '0) ? MODE_REPEAT : MODE_SINGLE;
            if (count_q != COUNT_MAX) begin
              count_d = count_q + 1'b1;
            end
          end
        end
        MODE_SINGLE, MODE_REPEAT: begin
          if (released_evt) begin
            mode_d = MODE_RELEASED;
          end else begin
            held_d = held_acc;
            if (held_acc > {{(HELD_W - LONG_W){1'b0}}, long_press_q}) begin
              mode_d = MODE_LONG;
            end
          end
        end
        MODE_LONG: begin
          if (released_evt) begin
            mode_d = MODE_RELEASED;
          end else begin
            held_d = held_acc;
          end
        end
        default: mode_d = MODE_RELEASED;
      endcase
    end
  end

  // Report for this event
  always_comb begin
    kind  = RPT_NONE;
    total = '0;
    if (mode_q == MODE_RELEASED && released_evt) begin
      kind  = RPT_CLICKS;
      total = count_q;
    end else if (mode_q == MODE_LONG && !released_evt) begin
      if (in_first) begin
        kind = RPT_FIRST;
      end else if (in_second) begin
        kind = RPT_SECOND;
      end
    end
  end

  // Load or drain the output register
  always_comb begin
    res_valid_d = res_valid_q;
    res_d       = res_q;
    if (evt_accept) begin
      res_valid_d       = 1'b1;
      res_d.report_kind = kind;
      res_d.click_total = total;
      res_d.mode_now    = mode_d;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_RELEASED;
      held_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      held_q      <= held_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.report_kind = res_q.report_kind;
  assign res_o.click_total = res_q.click_total;
  assign res_o.mode_now    = res_q.mode_now;

  // Reported mode matches the state it left behind
  a_mode_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_accept |=> (res_q.mode_now == mode_q))
    else $error("reported mode differs from state");

  // A click report only happens in released mode
  a_click_released : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.report_kind == RPT_CLICKS) |-> (res_q.mode_now == MODE_RELEASED))
    else $error("click report outside released mode");

  // Click report clears count and held time
  a_click_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_accept && mode_q == MODE_RELEASED && released_evt) |=>
      (held_q == '0 && count_q == '0))
    else $error("click report did not clear state");

  // A press from released always leaves a nonzero count
  a_press_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_accept && mode_q == MODE_RELEASED && !released_evt) |=> (count_q != '0))
    else $error("press did not count a click");

  // State stands still without an accepted event
  a_state_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !evt_accept |=> ($stable(mode_q) && $stable(held_q) && $stable(count_q)))
    else $error("state changed without an event");

endmodule
